// File: sv/vrc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the voxel ray caster.
// Used by vrc_voxel_map, voxel_ray_cast_3d and vrc_checker; depends on nothing.

package vrc_pkg;

    localparam int DIM_X_DEF   = 16;
    localparam int DIM_Y_DEF   = 16;
    localparam int DIM_Z_DEF   = 16;
    localparam int ADDR_W_DEF  = 12;

    localparam int CRD_W       = 8;
    localparam int POS_W       = 10;
    localparam int ERR_W       = 12;
    localparam int PT_W        = 4;
    localparam int MAX_RESULTS = 48;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 16;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic wr_en;
        logic wr_data;
    } map_req_t;

endpackage

// File: sv/vrc_voxel_map.sv
`timescale 1ns / 1ps
// Solid/open flag memory for the voxel chunk, with a clearing sweep after reset.
// Depends on vrc_pkg.

module vrc_voxel_map #(
    parameter int ADDR_W = vrc_pkg::ADDR_W_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vrc_pkg::map_req_t  req,
    input  logic [ADDR_W-1:0]  addr,
    output logic               rd_data,
    output logic               busy
);
    import vrc_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic              mem [DEPTH];
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              busy_reg;
    logic              busy_next;
    logic              rd_data_reg;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= 1'b0;
        end
        else if (req.wr_en)
        begin
            mem[addr] <= req.wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// File: sv/voxel_ray_cast_3d.sv
`timescale 1ns / 1ps
// Voxel ray caster: 3D Bresenham line walk through a chunk of solid/open flags.
// Depends on vrc_pkg and vrc_voxel_map.
// A write request is done as it is taken. A cast request is set up, then walks the major axis
// step by step, taking minor steps as the error terms call for, and closes with a last result.
// One map read per visited voxel; output stalls add their cycles and input waits meanwhile.
// After reset all 2**ADDR_W map entries (4096 at the default size) are swept clear.

module voxel_ray_cast_3d #(
    parameter int DIM_X = vrc_pkg::DIM_X_DEF,
    parameter int DIM_Y = vrc_pkg::DIM_Y_DEF,
    parameter int DIM_Z = vrc_pkg::DIM_Z_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, solid_flag, zero padding
    input  logic [vrc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // point_x, point_y, point_z, point_valid, hit_solid, zero padding
    output logic [vrc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);
    import vrc_pkg::*;

    localparam int XW     = $clog2(DIM_X);
    localparam int YW     = $clog2(DIM_Y);
    localparam int ZW     = $clog2(DIM_Z);
    localparam int ADDR_W = XW + YW + ZW;

    localparam logic signed [POS_W-1:0] LIM_X = POS_W'(DIM_X);
    localparam logic signed [POS_W-1:0] LIM_Y = POS_W'(DIM_Y);
    localparam logic signed [POS_W-1:0] LIM_Z = POS_W'(DIM_Z);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_SETUP  = 9'b000000100,
        S_LOOP   = 9'b000001000,
        S_MINOR  = 9'b000010000,
        S_ADV    = 9'b000100000,
        S_CHECK  = 9'b001000000,
        S_READ   = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        RET_MINOR = 2'd0,
        RET_ADV   = 2'd1,
        RET_DONE  = 2'd2
    } ret_t;

    function automatic logic in_chunk(input logic signed [POS_W-1:0] px,
                                      input logic signed [POS_W-1:0] py,
                                      input logic signed [POS_W-1:0] pz);
        in_chunk = !px[POS_W-1] && (px < LIM_X) && !py[POS_W-1] && (py < LIM_Y) &&
                   !pz[POS_W-1] && (pz < LIM_Z);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic signed [POS_W-1:0] px,
                                                  input logic signed [POS_W-1:0] py,
                                                  input logic signed [POS_W-1:0] pz);
        addr_of = {pz[ZW-1:0], py[YW-1:0], px[XW-1:0]};
    endfunction

    state_t                   state_reg, state_next;
    ret_t                     ret_reg, ret_next;
    logic signed [POS_W-1:0]  pos_reg [3];
    logic signed [POS_W-1:0]  pos_next [3];
    logic signed [CRD_W-1:0]  end_reg [3];
    logic signed [ERR_W-1:0]  e0_reg, e0_next, e1_reg, e1_next;
    logic                     ran_reg, ran_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CRD_W-1:0]         len_reg, d1_reg, d2_reg;
    logic [2:0]               neg_reg;
    axis_t                    maj_reg, m1_reg, m2_reg;
    logic                     pend_valid_reg, pend_valid_next;
    logic [PT_W-1:0]          pend_x_reg, pend_y_reg, pend_z_reg;
    logic                     pend_hit_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [PT_W-1:0]          out_x_reg, out_y_reg, out_z_reg;
    logic                     out_pv_reg, out_hit_reg, out_last_reg;

    logic signed [CRD_W-1:0]  in_start [3];
    logic signed [CRD_W-1:0]  in_end [3];
    logic signed [POS_W-1:0]  start_ext [3];
    logic signed [POS_W-1:0]  diff [3];
    logic [CRD_W-1:0]         ad [3];
    logic signed [POS_W-1:0]  end_maj;
    logic signed [ERR_W:0]    len_s;
    logic                     need0, need1;
    axis_t                    step_axis;
    logic signed [POS_W-1:0]  step_pos;
    logic                     out_free, push, push_last, pend_load, in_load, setup_load;
    map_req_t                 map_req;
    logic [ADDR_W-1:0]        map_addr;
    logic                     map_rd, map_busy;

    vrc_voxel_map #(
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .addr    (map_addr),
        .rd_data (map_rd),
        .busy    (map_busy)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_start[i]  = s_axis_tdata[i*CRD_W +: CRD_W];
            in_end[i]    = s_axis_tdata[(3+i)*CRD_W +: CRD_W];
            start_ext[i] = POS_W'(in_start[i]);
            diff[i]      = POS_W'(end_reg[i]) - pos_reg[i];
            ad[i]        = diff[i][POS_W-1] ? CRD_W'(-diff[i]) : CRD_W'(diff[i]);
        end
    end

    assign map_addr = (state_reg == S_IDLE)
                    ? addr_of(start_ext[0], start_ext[1], start_ext[2])
                    : addr_of(pos_reg[0], pos_reg[1], pos_reg[2]);

    assign end_maj   = POS_W'(end_reg[maj_reg]);
    assign len_s     = {{(ERR_W-CRD_W+1){1'b0}}, len_reg};
    assign need0     = $signed({e0_reg, 1'b0}) >= len_s;
    assign need1     = $signed({e1_reg, 1'b0}) >= len_s;
    assign step_axis = (state_reg == S_MINOR) ? ((e0_reg > e1_reg) ? m1_reg : m2_reg)
                                              : maj_reg;
    assign step_pos  = pos_reg[step_axis] + (neg_reg[step_axis] ? '1 : POS_W'(1));
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        pos_next        = pos_reg;
        e0_next         = e0_reg;
        e1_next         = e1_reg;
        ran_next        = ran_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        push            = 1'b0;
        push_last       = 1'b0;
        pend_load       = 1'b0;
        in_load         = 1'b0;
        setup_load      = 1'b0;
        map_req         = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (!map_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser[0])
                    begin
                        in_load    = 1'b1;
                        pos_next   = start_ext;
                        state_next = S_SETUP;
                    end
                    else if (in_chunk(start_ext[0], start_ext[1], start_ext[2]))
                    begin
                        map_req.wr_en   = 1'b1;
                        map_req.wr_data = s_axis_tdata[6*CRD_W];
                    end
                end
            end
            S_SETUP:
            begin
                setup_load      = 1'b1;
                e0_next         = '0;
                e1_next         = '0;
                cnt_next        = '0;
                pend_valid_next = 1'b0;
                state_next      = S_LOOP;
            end
            S_LOOP:
            begin
                if (pos_reg[maj_reg] == end_maj)
                begin
                    ret_next   = RET_DONE;
                    state_next = S_CHECK;
                end
                else
                begin
                    e0_next    = e0_reg + ERR_W'(d1_reg);
                    e1_next    = e1_reg + ERR_W'(d2_reg);
                    ran_next   = 1'b0;
                    state_next = S_MINOR;
                end
            end
            S_MINOR:
            begin
                if (need0 || need1)
                begin
                    if (e0_reg > e1_reg)
                    begin
                        e0_next = e0_reg - ERR_W'(len_reg);
                    end
                    else
                    begin
                        e1_next = e1_reg - ERR_W'(len_reg);
                    end
                    pos_next[step_axis] = step_pos;
                    ran_next   = 1'b1;
                    ret_next   = RET_MINOR;
                    state_next = S_CHECK;
                end
                else if (!ran_reg)
                begin
                    ret_next   = RET_ADV;
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                pos_next[maj_reg] = step_pos;
                ran_next   = 1'b0;
                state_next = S_LOOP;
            end
            S_CHECK:
            begin
                if (in_chunk(pos_reg[0], pos_reg[1], pos_reg[2]))
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    push            = pend_valid_reg;
                    pend_load       = 1'b1;
                    pend_valid_next = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                    if (map_rd || (cnt_reg == CNT_W'(MAX_RESULTS - 1)))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        case (ret_reg)
                            RET_MINOR: state_next = S_MINOR;
                            RET_ADV:   state_next = S_ADV;
                            default:   state_next = S_FINISH;
                        endcase
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (push)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ret_reg        <= RET_DONE;
            ran_reg        <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            ran_reg        <= ran_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        e0_reg  <= e0_next;
        e1_reg  <= e1_next;
        if (in_load)
        begin
            end_reg <= in_end;
        end
        if (setup_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= diff[i][POS_W-1];
            end
            if ((ad[0] >= ad[1]) && (ad[0] >= ad[2]))
            begin
                maj_reg <= AXIS_X;
                m1_reg  <= AXIS_Y;
                m2_reg  <= AXIS_Z;
                len_reg <= ad[0];
                d1_reg  <= ad[1];
                d2_reg  <= ad[2];
            end
            else if (ad[1] >= ad[2])
            begin
                maj_reg <= AXIS_Y;
                m1_reg  <= AXIS_X;
                m2_reg  <= AXIS_Z;
                len_reg <= ad[1];
                d1_reg  <= ad[0];
                d2_reg  <= ad[2];
            end
            else
            begin
                maj_reg <= AXIS_Z;
                m1_reg  <= AXIS_Y;
                m2_reg  <= AXIS_X;
                len_reg <= ad[2];
                d1_reg  <= ad[1];
                d2_reg  <= ad[0];
            end
        end
        if (pend_load)
        begin
            pend_x_reg   <= pos_reg[0][PT_W-1:0];
            pend_y_reg   <= pos_reg[1][PT_W-1:0];
            pend_z_reg   <= pos_reg[2][PT_W-1:0];
            pend_hit_reg <= map_rd;
        end
        if (push)
        begin
            out_x_reg    <= pend_valid_reg ? pend_x_reg : '0;
            out_y_reg    <= pend_valid_reg ? pend_y_reg : '0;
            out_z_reg    <= pend_valid_reg ? pend_z_reg : '0;
            out_pv_reg   <= pend_valid_reg;
            out_hit_reg  <= pend_valid_reg && pend_hit_reg;
            out_last_reg <= push_last;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-3*PT_W-2){1'b0}}, out_hit_reg, out_pv_reg,
                            out_z_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: sv/vrc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the voxel ray caster, bound to voxel_ray_cast_3d.
// Depends on vrc_pkg.

module vrc_port_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [0:0]                     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [vrc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);
    import vrc_pkg::*;

    localparam int PV_BIT  = 3 * PT_W;
    localparam int HIT_BIT = 3 * PT_W + 1;

    // A stalled result keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // A cast without any visited voxel gives one empty result that closes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[PV_BIT] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty result is not a clean closing result");

    // A solid voxel stops the walk, so it is a real point and the final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[HIT_BIT] |-> m_axis_tlast && m_axis_tdata[PV_BIT])
        else $error("solid hit not flagged as final point");

    // A cast request keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
        else $error("input taken straight after a cast request");

endmodule

bind voxel_ray_cast_3d vrc_port_checker u_vrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/vrc_checker.sv
`timescale 1ns / 1ps
// Request kinds and the result checker for the voxel ray caster testbench.
// Depends on vrc_pkg; watches both stream channels of voxel_ray_cast_3d.

package vrc_tb_pkg;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_CAST  = 1'b1
    } req_kind_t;

endpackage

module vrc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [vrc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [0:0]                      s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [vrc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tlast,
    output int                              mismatches,
    output int                              outstanding
);

    import vrc_pkg::*;
    import vrc_tb_pkg::*;

    localparam int MAP_DEPTH = DIM_X_DEF * DIM_Y_DEF * DIM_Z_DEF;

    typedef struct packed {
        logic [PT_W-1:0] x;
        logic [PT_W-1:0] y;
        logic [PT_W-1:0] z;
        logic            valid;
        logic            hit;
        logic            last;
    } voxel_hit_t;

    bit         solid_map [MAP_DEPTH];
    voxel_hit_t pending_voxels [$];
    int         walk_emitted;
    voxel_hit_t got;
    voxel_hit_t want;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic bit in_chunk(input int px, input int py, input int pz);
        return px >= 0 && px < DIM_X_DEF && py >= 0 && py < DIM_Y_DEF &&
               pz >= 0 && pz < DIM_Z_DEF;
    endfunction

    function automatic int voxel_index(input int px, input int py, input int pz);
        return px + DIM_X_DEF * (py + DIM_Y_DEF * pz);
    endfunction

    // Emits the voxel if it lies in the chunk and the result limit is not reached; returns whether the walk goes on.
    function automatic bit visit_voxel(input int px, input int py, input int pz);
        voxel_hit_t r;
        bit         solid;
        if (!in_chunk(px, py, pz) || walk_emitted >= MAX_RESULTS)
            return 1'b0;
        solid   = solid_map[voxel_index(px, py, pz)];
        r.x     = px[PT_W-1:0];
        r.y     = py[PT_W-1:0];
        r.z     = pz[PT_W-1:0];
        r.valid = 1'b1;
        r.hit   = solid;
        r.last  = 1'b0;
        pending_voxels.push_back(r);
        walk_emitted++;
        return !(solid || walk_emitted >= MAX_RESULTS);
    endfunction

    function automatic void trace_ray(input logic [IN_DATA_W-1:0] req);
        int         st [3];
        int         en [3];
        int         ad [3];
        int         sg [3];
        int         pos [3];
        int         i;
        int         span;
        int         d1;
        int         d2;
        int         err1;
        int         err2;
        axis_t      major;
        axis_t      m1;
        axis_t      m2;
        bit         go_on;
        bit         stepped;
        voxel_hit_t r;
        walk_emitted = 0;
        for (i = 0; i < 3; i++)
        begin
            st[i]  = $signed(req[CRD_W*i +: CRD_W]);
            en[i]  = $signed(req[CRD_W*(i+3) +: CRD_W]);
            ad[i]  = (en[i] > st[i]) ? en[i] - st[i] : st[i] - en[i];
            sg[i]  = (en[i] > st[i]) ? 1 : ((en[i] < st[i]) ? -1 : 0);
            pos[i] = st[i];
        end
        if (ad[AXIS_X] >= ad[AXIS_Y] && ad[AXIS_X] >= ad[AXIS_Z])
        begin
            major = AXIS_X;
            m1    = AXIS_Y;
            m2    = AXIS_Z;
        end
        else if (ad[AXIS_Y] >= ad[AXIS_Z])
        begin
            major = AXIS_Y;
            m1    = AXIS_X;
            m2    = AXIS_Z;
        end
        else
        begin
            major = AXIS_Z;
            m1    = AXIS_Y;
            m2    = AXIS_X;
        end
        span  = ad[major];
        d1    = ad[m1];
        d2    = ad[m2];
        err1  = 0;
        err2  = 0;
        go_on = 1'b1;
        while (pos[major] != en[major] && go_on)
        begin
            err1 += d1;
            err2 += d2;
            stepped = 1'b0;
            while (go_on && (2 * err1 >= span || 2 * err2 >= span))
            begin
                if (err1 > err2)
                begin
                    err1    -= span;
                    pos[m1] += sg[m1];
                end
                else
                begin
                    err2    -= span;
                    pos[m2] += sg[m2];
                end
                go_on   = visit_voxel(pos[0], pos[1], pos[2]);
                stepped = 1'b1;
            end
            if (!stepped)
                go_on = visit_voxel(pos[0], pos[1], pos[2]);
            pos[major] += sg[major];
        end
        if (go_on)
            void'(visit_voxel(pos[0], pos[1], pos[2]));
        if (walk_emitted == 0)
        begin
            r      = '0;
            r.last = 1'b1;
            pending_voxels.push_back(r);
        end
        else
        begin
            r      = pending_voxels.pop_back();
            r.last = 1'b1;
            pending_voxels.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (req_kind_t'(s_axis_tuser[0]) == REQ_CAST)
                    trace_ray(s_axis_tdata);
                else if (in_chunk($signed(s_axis_tdata[7:0]), $signed(s_axis_tdata[15:8]),
                                  $signed(s_axis_tdata[23:16])))
                    solid_map[voxel_index($signed(s_axis_tdata[7:0]),
                                          $signed(s_axis_tdata[15:8]),
                                          $signed(s_axis_tdata[23:16]))] = s_axis_tdata[48];
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.x     = m_axis_tdata[3:0];
                got.y     = m_axis_tdata[7:4];
                got.z     = m_axis_tdata[11:8];
                got.valid = m_axis_tdata[12];
                got.hit   = m_axis_tdata[13];
                got.last  = m_axis_tlast;
                if (pending_voxels.size() == 0)
                begin
                    $error("unexpected result: x %0d y %0d z %0d valid %0d hit %0d last %0d",
                           got.x, got.y, got.z, got.valid, got.hit, got.last);
                    mismatches++;
                end
                else
                begin
                    want = pending_voxels.pop_front();
                    check_field("point_x", want.x, got.x);
                    check_field("point_y", want.y, got.y);
                    check_field("point_z", want.z, got.z);
                    check_field("point_valid", want.valid, got.valid);
                    check_field("hit_solid", want.hit, got.hit);
                    check_field("last", want.last, got.last);
                end
            end
            outstanding = pending_voxels.size();
        end
    end

endmodule

// File: tb/tb_voxel_ray_cast_3d.sv
`timescale 1ns / 1ps
// Testbench top for voxel_ray_cast_3d: clock, reset, write and cast requests, and the verdict.
// Depends on vrc_pkg, vrc_checker (with vrc_tb_pkg) and the block itself.

module tb_voxel_ray_cast_3d;

    import vrc_pkg::*;
    import vrc_tb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 64;
    localparam int RANDOM_PER_PHASE = 19;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit pressure_req = 1'b0;
    int quiet_cycles = 0;
    int tgt_x = 5;
    int tgt_y = 5;
    int tgt_z = 5;

    voxel_ray_cast_3d u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    vrc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever
            #10 clk = ~clk;
    end

    function automatic logic [CRD_W-1:0] rand_coord(input int lo, input int hi);
        int v;
        v = lo + int'($urandom_range(hi - lo));
        return v[CRD_W-1:0];
    endfunction

    function automatic logic [IN_DATA_W-1:0] make_request(input int sx, input int sy,
                                                          input int sz, input int ex,
                                                          input int ey, input int ez,
                                                          input logic flag);
        return {7'b0, flag, ez[7:0], ey[7:0], ex[7:0], sz[7:0], sy[7:0], sx[7:0]};
    endfunction

    task automatic push_request(input req_kind_t kind, input logic [IN_DATA_W-1:0] payload);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= payload;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_voxel(input int x, input int y, input int z, input logic flag);
        push_request(REQ_WRITE, make_request(x, y, z, $urandom, $urandom, $urandom, flag));
    endtask

    task automatic cast_ray(input int sx, input int sy, input int sz,
                            input int ex, input int ey, input int ez);
        push_request(REQ_CAST, make_request(sx, sy, sz, ex, ey, ez, 1'($urandom_range(1))));
    endtask

    // Most casts start inside the chunk; many aim at the voxel of the last write that set the
    // target, so that solid hits are common.
    task automatic random_request();
        logic [CRD_W-1:0] sx;
        logic [CRD_W-1:0] sy;
        logic [CRD_W-1:0] sz;
        logic [CRD_W-1:0] ex;
        logic [CRD_W-1:0] ey;
        logic [CRD_W-1:0] ez;
        int               pick;
        pick = $urandom_range(99);
        sx   = rand_coord(-1, 16);
        sy   = rand_coord(-1, 16);
        sz   = rand_coord(-1, 16);
        ex   = CRD_W'($urandom);
        ey   = CRD_W'($urandom);
        ez   = CRD_W'($urandom);
        if (pick < 30)
        begin
            if (pick < 3)
            begin
                sx = CRD_W'($urandom);
                sy = CRD_W'($urandom);
                sz = CRD_W'($urandom);
            end
            else if (pick < 24)
            begin
                tgt_x = $signed(sx);
                tgt_y = $signed(sy);
                tgt_z = $signed(sz);
            end
            push_request(REQ_WRITE, make_request($signed(sx), $signed(sy), $signed(sz),
                                                 ex, ey, ez, $urandom_range(99) < 75));
        end
        else
        begin
            if (pick < 60)
            begin
                ex = tgt_x[CRD_W-1:0];
                ey = tgt_y[CRD_W-1:0];
                ez = tgt_z[CRD_W-1:0];
            end
            else if (pick < 85)
            begin
                ex = rand_coord(-20, 35);
                ey = rand_coord(-20, 35);
                ez = rand_coord(-20, 35);
            end
            if ($urandom_range(9) == 0)
            begin
                sx = CRD_W'($urandom);
                sy = CRD_W'($urandom);
                sz = CRD_W'($urandom);
            end
            cast_ray($signed(sx), $signed(sy), $signed(sz),
                     $signed(ex), $signed(ey), $signed(ez));
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (pressure_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(negedge clk);
                pressure_req = 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_voxel(0, 0, 0, 1'b1);
        cast_ray(0, 0, 0, 10, 0, 0);
        write_voxel(0, 0, 0, 1'b0);
        write_voxel(5, 5, 5, 1'b1);
        write_voxel(15, 15, 15, 1'b1);
        write_voxel(-1, 3, 3, 1'b1);
        write_voxel(16, 0, 0, 1'b1);
        write_voxel(127, -128, -128, 1'b1);
        cast_ray(0, 0, 0, 15, 0, 0);
        cast_ray(0, 0, 0, 0, 15, 0);
        cast_ray(0, 0, 0, 0, 0, 15);
        cast_ray(3, 3, 3, 3, 3, 3);
        cast_ray(0, 0, 0, 127, 127, 127);
        cast_ray(-128, -128, -128, 127, 127, 127);
        cast_ray(20, 5, 5, 0, 5, 5);
        cast_ray(5, 5, 0, 5, 5, 15);
        cast_ray(15, 15, 0, 15, 15, 127);
        cast_ray(0, -1, 0, 2, 1, 0);
        cast_ray(8, 8, 8, -128, 127, -128);
        cast_ray(2, 0, 0, 9, 3, 1);
        cast_ray(0, 0, 0, 4, 2, 2);
        write_voxel(5, 5, 5, 1'b0);
        cast_ray(1, 2, 0, 4, 7, 12);
        cast_ray(15, 15, 15, 0, 3, 9);
        cast_ray(14, 14, 14, 0, 3, 9);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    pressure_req   = 1'b1;
                end
                1:
                begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
                random_request();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
